// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rainbow colouriser RTL.
// Each macro expects the including module to have i_clk and i_rst_n ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define RAC_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define RAC_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/rac_pkg.sv =====
// Package for the rainbow colouriser: widths, character codes, record types,
// and the sine and decimal tables built at elaboration. No dependencies.
`default_nettype none

package rac_pkg;

    // Phase and sine table geometry
    localparam int PHASE_BITS     = 16;
    localparam int SINE_ADDR_BITS = 10;
    localparam int QBITS          = SINE_ADDR_BITS - 2;
    localparam int QDEPTH         = 1 << QBITS;

    typedef logic [PHASE_BITS-1:0] t_phase;

    // One third and two thirds of a turn, rounded
    localparam t_phase PH_THIRD =
        t_phase'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
    localparam t_phase PH_TWO_THIRDS =
        t_phase'(((64'd2 << PHASE_BITS) + 64'd1) / 64'd3);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Channel levels
    localparam logic [7:0] MID_LEVEL  = 8'd128;
    localparam logic [7:0] PEAK_HIGH  = 8'd255;
    localparam logic [7:0] PEAK_LOW   = 8'd1;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_COLUMN_STEP = 3'd0,
        CFG_LINE_STEP   = 3'd1,
        CFG_TRUE_COLOR  = 3'd2,
        CFG_INVERT      = 3'd3,
        CFG_ENABLE      = 3'd4
    } t_cfg_index;

    localparam logic [15:0] RST_COLUMN_STEP = 16'd3129;
    localparam logic [15:0] RST_LINE_STEP   = 16'd1043;

    typedef struct packed {
        logic [15:0] col_step;
        logic [15:0] line_step;
        logic        true_color;
        logic        invert;
        logic        enable;
    } t_cfg;

    // Colour stage to formatter
    typedef struct packed {
        logic [7:0] text;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       change;
        logic       true_color;
        logic       invert;
    } t_colour_rec;

    // Character codes
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ONE       = 8'h31;
    localparam logic [7:0] CH_TWO       = 8'h32;
    localparam logic [7:0] CH_THREE     = 8'h33;
    localparam logic [7:0] CH_FOUR      = 8'h34;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_EIGHT     = 8'h38;
    localparam logic [7:0] CH_M         = 8'h6D;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    // Output run layout: fixed slots, the text byte always in the top one
    localparam int SLOT_COUNT = 20;
    localparam int SLOT_TEXT  = SLOT_COUNT - 1;

    // Unsigned quotient by shift and subtract, used for the table build only
    function automatic longint unsigned shift_sub_quotient(input longint unsigned num,
                                                           input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave table: {floor(127*sin), fraction nonzero} per step
    typedef logic [QDEPTH-1:0][7:0] t_sine_tab;

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned m;
        for (int j = 0; j < QDEPTH; j++) begin
            x    = (longint'(j) * HALF_PI_Q30) >> QBITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 6; k++) begin
                term = shift_sub_quotient((term * x2) >> 30,
                                          64'((2 * k) * (2 * k + 1)));
                if ((k & 1) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            m      = 64'd127 * sum;
            tab[j] = {7'(m >> 30), (m[29:0] != 30'd0)};
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_tab();

    // Decimal digits {hundreds, tens, ones} of 0..255
    typedef logic [255:0][11:0] t_dec_tab;

    function automatic t_dec_tab build_dec_tab();
        t_dec_tab tab;
        int       hundreds;
        int       tens;
        int       ones;
        for (int v = 0; v < 256; v++) begin
            // count off hundreds and tens by subtraction
            hundreds = 0;
            tens     = 0;
            ones     = v;
            while (ones >= 100) begin
                ones     = ones - 100;
                hundreds = hundreds + 1;
            end
            while (ones >= 10) begin
                ones = ones - 10;
                tens = tens + 1;
            end
            tab[v] = {4'(hundreds), 4'(tens), 4'(ones)};
        end
        return tab;
    endfunction

    localparam t_dec_tab DEC_TAB = build_dec_tab();

    // 128 + 127*sin(phase), floor above the axis and ceiling below
    function automatic logic [7:0] channel_level(input t_phase phase);
        logic [PHASE_BITS+SINE_ADDR_BITS-1:0] wide;
        logic [SINE_ADDR_BITS-1:0]            addr;
        logic [1:0]                           quad;
        logic [QBITS-1:0]                     j;
        logic [QBITS-1:0]                     t;
        logic [7:0]                           e;
        logic [7:0]                           level;
        wide = {phase, {SINE_ADDR_BITS{1'b0}}};
        addr = wide[PHASE_BITS+SINE_ADDR_BITS-1 -: SINE_ADDR_BITS];
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        j    = addr[QBITS-1:0];
        t    = quad[0] ? ({QBITS{1'b0}} - j) : j;
        e    = SINE_TAB[t];
        if (quad[0] && (j == {QBITS{1'b0}})) begin
            level = quad[1] ? PEAK_LOW : PEAK_HIGH;
        end else if (!quad[1]) begin
            level = MID_LEVEL + {1'b0, e[7:1]};
        end else begin
            level = MID_LEVEL - {1'b0, e[7:1]} - {7'd0, e[0]};
        end
        return level;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rac_colour.sv =====
// Colour stage: escape tracking, line and column phase, sine lookups and the
// colour-change test; holds one record for the formatter. Uses rac_pkg.
`default_nettype none

`include "assert_macros.svh"

module rac_colour (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rac_pkg::t_cfg       i_cfg,
    input  wire                 i_in_valid,
    input  wire  [7:0]          i_in_byte,
    output logic                o_in_ready,
    output logic                o_rec_valid,
    output rac_pkg::t_colour_rec o_rec,
    input  wire                 i_rec_ready
);

    logic                 r_in_escape, n_in_escape;
    rac_pkg::t_phase      r_col_phase, n_col_phase;
    rac_pkg::t_phase      r_line_phase, n_line_phase;
    logic [7:0]           r_last_red, n_last_red;
    logic [7:0]           r_last_green, n_last_green;
    logic [7:0]           r_last_blue, n_last_blue;
    logic                 r_out_valid, n_out_valid;
    rac_pkg::t_colour_rec r_rec, n_rec;

    logic                 is_esc;
    logic                 is_term;
    logic                 emits;
    logic                 out_free;
    logic                 adv;
    rac_pkg::t_phase      phase_a;
    logic [7:0]           red_full, green_full, blue_full;
    logic [7:0]           red, green, blue;
    logic                 change;

    // Work out the colour for the held word and the next state
    always_comb begin
        is_esc  = (i_in_byte == rac_pkg::CH_ESC);
        is_term = ((i_in_byte >= rac_pkg::CH_UPPER_A) && (i_in_byte <= rac_pkg::CH_UPPER_Z))
               || ((i_in_byte >= rac_pkg::CH_LOWER_A) && (i_in_byte <= rac_pkg::CH_LOWER_Z))
               || (i_in_byte == rac_pkg::CH_BEL);
        emits    = !i_cfg.enable || (!is_esc && !r_in_escape);
        out_free = !r_out_valid || i_rec_ready;
        o_in_ready = !emits || out_free;
        adv        = i_in_valid && o_in_ready;

        phase_a    = r_col_phase + r_line_phase;
        red_full   = rac_pkg::channel_level(phase_a);
        green_full = rac_pkg::channel_level(phase_a + rac_pkg::PH_THIRD);
        blue_full  = rac_pkg::channel_level(phase_a + rac_pkg::PH_TWO_THIRDS);

        // 16-colour mode keeps the top two bits of each channel
        if (i_cfg.true_color) begin
            red   = red_full;
            green = green_full;
            blue  = blue_full;
        end else begin
            red   = {6'd0, red_full[7:6]};
            green = {6'd0, green_full[7:6]};
            blue  = {6'd0, blue_full[7:6]};
        end
        change = i_cfg.enable
              && ((red != r_last_red) || (green != r_last_green) || (blue != r_last_blue));

        n_in_escape  = r_in_escape;
        n_col_phase  = r_col_phase;
        n_line_phase = r_line_phase;
        n_last_red   = r_last_red;
        n_last_green = r_last_green;
        n_last_blue  = r_last_blue;

        if (adv && i_cfg.enable) begin
            if (is_esc) begin
                n_in_escape = 1'b1;
            end else if (r_in_escape) begin
                if (is_term) begin
                    n_in_escape = 1'b0;
                end
            end else begin
                n_col_phase = r_col_phase + rac_pkg::t_phase'(i_cfg.col_step);
                if (i_in_byte == rac_pkg::CH_NL) begin
                    n_col_phase  = '0;
                    n_line_phase = r_line_phase + rac_pkg::t_phase'(i_cfg.line_step);
                end
                if (change) begin
                    n_last_red   = red;
                    n_last_green = green;
                    n_last_blue  = blue;
                end
            end
        end

        // Hold the record until the formatter takes it
        if (adv && emits) begin
            n_out_valid = 1'b1;
        end else if (i_rec_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        n_rec = r_rec;
        if (adv && emits) begin
            n_rec.text       = i_in_byte;
            n_rec.red        = red;
            n_rec.green      = green;
            n_rec.blue       = blue;
            n_rec.change     = change;
            n_rec.true_color = i_cfg.true_color;
            n_rec.invert     = i_cfg.invert;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_escape  <= 1'b0;
            r_col_phase  <= '0;
            r_line_phase <= '0;
            r_last_red   <= 8'd0;
            r_last_green <= 8'd0;
            r_last_blue  <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_escape  <= n_in_escape;
            r_col_phase  <= n_col_phase;
            r_line_phase <= n_line_phase;
            r_last_red   <= n_last_red;
            r_last_green <= n_last_green;
            r_last_blue  <= n_last_blue;
            r_out_valid  <= n_out_valid;
        end
    end

    // Record payload
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec_valid = r_out_valid;
    assign o_rec       = r_rec;

    `RAC_ASSERT_NXT(a_record_follows_take, adv && emits, r_out_valid,
                    "colour record missing after a taken word")
    `RAC_ASSERT_NXT(a_bypass_keeps_phase, adv && !i_cfg.enable, $stable(r_col_phase),
                    "column phase moved while colouring was off")

endmodule

`default_nettype wire

// ===== rtl/rac_format.sv =====
// Formatter and output register: lays out the escape run in fixed slots and
// sends the kept slots one word per cycle while m_axis_tready is high. Uses rac_pkg.
`default_nettype none

`include "assert_macros.svh"

module rac_format (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_rec_valid,
    input  rac_pkg::t_colour_rec i_rec,
    output logic                 o_rec_ready,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic [rac_pkg::SLOT_COUNT-1:0][7:0] r_slots, n_slots;
    logic [rac_pkg::SLOT_COUNT-1:0]      r_keep, n_keep;

    logic [rac_pkg::SLOT_COUNT-1:0][7:0] new_slots;
    logic [rac_pkg::SLOT_COUNT-1:0]      new_keep;
    logic [rac_pkg::SLOT_COUNT-1:0]      low;
    logic [rac_pkg::SLOT_COUNT-1:0]      rest;
    logic [11:0]                         dec_r, dec_g, dec_b;
    logic                                bold;
    logic [7:0]                          out_byte;

    // Lay out the run for the incoming record
    always_comb begin
        dec_r = rac_pkg::DEC_TAB[i_rec.red];
        dec_g = rac_pkg::DEC_TAB[i_rec.green];
        dec_b = rac_pkg::DEC_TAB[i_rec.blue];
        bold  = i_rec.red[1] | i_rec.blue[1] | i_rec.text[1];

        new_slots = '0;
        new_keep  = '0;
        new_slots[rac_pkg::SLOT_TEXT] = i_rec.text;
        new_keep[rac_pkg::SLOT_TEXT]  = 1'b1;
        new_slots[0] = rac_pkg::CH_ESC;
        new_slots[1] = rac_pkg::CH_LBRACKET;

        if (i_rec.true_color) begin
            // ESC [ 3|4 8 ; 2 ; R ; G ; B m
            new_slots[2]  = i_rec.invert ? rac_pkg::CH_FOUR : rac_pkg::CH_THREE;
            new_slots[3]  = rac_pkg::CH_EIGHT;
            new_slots[4]  = rac_pkg::CH_SEMI;
            new_slots[5]  = rac_pkg::CH_TWO;
            new_slots[6]  = rac_pkg::CH_SEMI;
            new_slots[7]  = rac_pkg::CH_ZERO | {4'd0, dec_r[11:8]};
            new_slots[8]  = rac_pkg::CH_ZERO | {4'd0, dec_r[7:4]};
            new_slots[9]  = rac_pkg::CH_ZERO | {4'd0, dec_r[3:0]};
            new_slots[10] = rac_pkg::CH_SEMI;
            new_slots[11] = rac_pkg::CH_ZERO | {4'd0, dec_g[11:8]};
            new_slots[12] = rac_pkg::CH_ZERO | {4'd0, dec_g[7:4]};
            new_slots[13] = rac_pkg::CH_ZERO | {4'd0, dec_g[3:0]};
            new_slots[14] = rac_pkg::CH_SEMI;
            new_slots[15] = rac_pkg::CH_ZERO | {4'd0, dec_b[11:8]};
            new_slots[16] = rac_pkg::CH_ZERO | {4'd0, dec_b[7:4]};
            new_slots[17] = rac_pkg::CH_ZERO | {4'd0, dec_b[3:0]};
            new_slots[18] = rac_pkg::CH_M;
            if (i_rec.change) begin
                new_keep     = '1;
                // drop leading zeros
                new_keep[7]  = (dec_r[11:8] != 4'd0);
                new_keep[8]  = (dec_r[11:8] != 4'd0) || (dec_r[7:4] != 4'd0);
                new_keep[11] = (dec_g[11:8] != 4'd0);
                new_keep[12] = (dec_g[11:8] != 4'd0) || (dec_g[7:4] != 4'd0);
                new_keep[15] = (dec_b[11:8] != 4'd0);
                new_keep[16] = (dec_b[11:8] != 4'd0) || (dec_b[7:4] != 4'd0);
            end
        end else begin
            // ESC [ {7;} {1|21} ; 3 D m
            new_slots[2] = rac_pkg::CH_SEVEN;
            new_slots[3] = rac_pkg::CH_SEMI;
            new_slots[4] = rac_pkg::CH_TWO;
            new_slots[5] = rac_pkg::CH_ONE;
            new_slots[6] = rac_pkg::CH_SEMI;
            new_slots[7] = rac_pkg::CH_THREE;
            new_slots[8] = rac_pkg::CH_ZERO
                         | {5'd0, (i_rec.blue != 8'd0), (i_rec.green != 8'd0),
                            (i_rec.red != 8'd0)};
            new_slots[9] = rac_pkg::CH_M;
            if (i_rec.change) begin
                new_keep[0] = 1'b1;
                new_keep[1] = 1'b1;
                new_keep[2] = i_rec.invert;
                new_keep[3] = i_rec.invert;
                new_keep[4] = !bold;
                new_keep[5] = 1'b1;
                new_keep[6] = 1'b1;
                new_keep[7] = 1'b1;
                new_keep[8] = 1'b1;
                new_keep[9] = 1'b1;
            end
        end
    end

    // Pick the lowest kept slot and advance through the run
    always_comb begin
        low  = r_keep & (~r_keep + rac_pkg::SLOT_COUNT'(1));
        rest = r_keep & (r_keep - rac_pkg::SLOT_COUNT'(1));
        out_byte = 8'd0;
        for (int i = 0; i < rac_pkg::SLOT_COUNT; i++) begin
            out_byte = out_byte | (low[i] ? r_slots[i] : 8'd0);
        end
        m_axis_tvalid = (r_keep != '0);
        m_axis_tdata  = out_byte;
        m_axis_tlast  = (rest == '0);
        o_rec_ready   = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);

        n_keep  = r_keep;
        n_slots = r_slots;
        if (i_rec_valid && o_rec_ready) begin
            n_keep  = new_keep;
            n_slots = new_slots;
        end else if (m_axis_tvalid && m_axis_tready) begin
            n_keep = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0;
        end else begin
            r_keep <= n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slots <= n_slots;
    end

    `RAC_ASSERT_IMP(a_text_slot_kept, m_axis_tvalid, r_keep[rac_pkg::SLOT_TEXT],
                    "run lost its text byte")
    `RAC_ASSERT_NXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                    m_axis_tvalid, "run ended without a last word")

endmodule

`default_nettype wire

// ===== rtl/rainbow_ansi_text_colorizer.sv =====
// Rainbow ANSI text colouriser top level: configuration registers, input
// register, colour stage and formatter. Uses rac_pkg, rac_colour, rac_format.
//
// Usage:
//   Text bytes enter on the s_axis channel, one byte per word. Each byte
//   gives a run of 0 to 20 words on m_axis: an optional colour escape and
//   then the byte itself, which carries tlast. ESC sequences are swallowed
//   while colouring is enabled. Registers are written over the cfg channel
//   (always ready); the user must write them only while the block is idle,
//   as the block itself does not enforce it; index 0 column step, 1 line
//   step, 2 true colour, 3 invert, 4 enable; other indexes are ignored.
//   A byte passes the input, colour and output run registers in that order.
//   Throughput: one input byte per cycle while each yields a single word
//   and m_axis_tready stays high; a longer run holds the output port until
//   its last word is taken, which sets the rate, and the input register and
//   colour register keep taking words meanwhile until both are full.
//   Reset clears the phases, the last colour, the escape flag and all
//   pipeline valids, and loads the register defaults.
//   A stall on m_axis_tready holds the current word and backs up through
//   the stages to s_axis_tready; nothing is lost or repeated.
`default_nettype none

module rainbow_ansi_text_colorizer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // input text: tdata[7:0] = in_byte
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,
    // output run: tdata[7:0] = out_byte, tlast = last_of_run
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    // configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [rac_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire  [rac_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    rac_pkg::t_cfg        r_cfg;
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 colour_ready;
    logic                 rec_valid;
    logic                 rec_ready;
    rac_pkg::t_colour_rec rec;

    assign o_cfg_ready = 1'b1;

    // Decode register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.col_step   <= rac_pkg::RST_COLUMN_STEP;
            r_cfg.line_step  <= rac_pkg::RST_LINE_STEP;
            r_cfg.true_color <= 1'b0;
            r_cfg.invert     <= 1'b0;
            r_cfg.enable     <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rac_pkg::CFG_COLUMN_STEP: r_cfg.col_step   <= i_cfg_data[15:0];
                rac_pkg::CFG_LINE_STEP:   r_cfg.line_step  <= i_cfg_data[15:0];
                rac_pkg::CFG_TRUE_COLOR:  r_cfg.true_color <= i_cfg_data[0];
                rac_pkg::CFG_INVERT:      r_cfg.invert     <= i_cfg_data[0];
                rac_pkg::CFG_ENABLE:      r_cfg.enable     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register: take a word whenever the held one moves on
    assign s_axis_tready = !r_in_valid || colour_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (colour_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    rac_colour u_colour (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (r_in_valid),
        .i_in_byte   (r_in_byte),
        .o_in_ready  (colour_ready),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_ready (rec_ready)
    );

    rac_format u_format (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (rec_valid),
        .i_rec         (rec),
        .o_rec_ready   (rec_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/rainbow_ansi_text_colorizer_test.sv =====
// Self-checking testbench for the rainbow ANSI text colouriser: directed and random text
// streams against a cycle-free colour predictor, with random stalls on both streams.
// Depends on rac_pkg and the rainbow_ansi_text_colorizer top level.

module rainbow_ansi_text_colorizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                                  WATCHDOG_LIMIT  = 5000;
    localparam int                                  DRAIN_CYCLES    = 16;
    localparam int                                  LONG_STALL      = 300;
    localparam int                                  MAX_REPORTS     = 10;
    localparam logic [rac_pkg::CFG_INDEX_BITS-1:0]  CFG_SPARE_FIRST = 3'd5;
    localparam logic [rac_pkg::CFG_INDEX_BITS-1:0]  CFG_SPARE_LAST  = 3'd7;
    localparam logic [7:0]                          CH_RBRACKET     = 8'h5D;
    localparam longint unsigned                     Q30_UNITY       = 64'd1 << 30;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_word;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;   // [7:0] in_byte
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [7:0]                         m_axis_tdata;   // [7:0] out_byte
    logic                               m_axis_tlast;   // last_of_run
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [rac_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [rac_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    // Predicted registers and state of the colouriser
    logic [15:0]     pr_col_step;
    logic [15:0]     pr_line_step;
    logic            pr_true_color;
    logic            pr_invert;
    logic            pr_enable;
    logic            pr_in_escape;
    rac_pkg::t_phase pr_line_phase;
    rac_pkg::t_phase pr_col_phase;
    logic [7:0]      pr_last_red;
    logic [7:0]      pr_last_green;
    logic [7:0]      pr_last_blue;

    t_out_word run_words_due[$];
    int        fail_count    = 0;
    int        sent_count    = 0;
    bit        idle_on       = 1'b1;
    int        stall_request = 0;
    int        sink_gap      = 0;

    rainbow_ansi_text_colorizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Colour predictor
    // ------------------------------------------------------------------

    function automatic void reset_predictor();
        pr_col_step   = rac_pkg::RST_COLUMN_STEP;
        pr_line_step  = rac_pkg::RST_LINE_STEP;
        pr_true_color = 1'b0;
        pr_invert     = 1'b0;
        pr_enable     = 1'b1;
        pr_in_escape  = 1'b0;
        pr_line_phase = '0;
        pr_col_phase  = '0;
        pr_last_red   = '0;
        pr_last_green = '0;
        pr_last_blue  = '0;
    endfunction

    function automatic void apply_register(input logic [rac_pkg::CFG_INDEX_BITS-1:0] index,
                                           input logic [15:0] data);
        case (index)
            rac_pkg::CFG_COLUMN_STEP: pr_col_step   = data;
            rac_pkg::CFG_LINE_STEP:   pr_line_step  = data;
            rac_pkg::CFG_TRUE_COLOR:  pr_true_color = data[0];
            rac_pkg::CFG_INVERT:      pr_invert     = data[0];
            rac_pkg::CFG_ENABLE:      pr_enable     = data[0];
            default: ;
        endcase
    endfunction

    // Q30 sine of qj/QDEPTH of a quarter turn, Taylor series through x^13
    function automatic longint unsigned quarter_sine_q30(input int unsigned qj);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        if (qj >= rac_pkg::QDEPTH) begin
            sum = Q30_UNITY;
        end else begin
            x    = 64'(qj);
            x    = (x * rac_pkg::HALF_PI_Q30) >> rac_pkg::QBITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 6; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // 128 + 127*sin: floor on the upper half wave, ceiling of the magnitude below
    function automatic logic [7:0] rainbow_level(input rac_pkg::t_phase phase);
        logic [rac_pkg::SINE_ADDR_BITS-1:0] addr;
        int unsigned                        quad;
        int unsigned                        j;
        int unsigned                        t;
        longint unsigned                    m;
        logic [7:0]                         level;
        addr = phase[rac_pkg::PHASE_BITS-1 -: rac_pkg::SINE_ADDR_BITS];
        quad = {30'd0, addr[rac_pkg::SINE_ADDR_BITS-1 -: 2]};
        j    = {{(32 - rac_pkg::QBITS){1'b0}}, addr[rac_pkg::QBITS-1:0]};
        t    = (quad % 2 == 1) ? (rac_pkg::QDEPTH - j) : j;
        m    = 64'd127 * quarter_sine_q30(t);
        if (quad < 2) begin
            level = 8'(64'd128 + (m >> 30));
        end else begin
            level = 8'(64'd128 - ((m + Q30_UNITY - 64'd1) >> 30));
        end
        return level;
    endfunction

    function automatic void push_word(input logic [7:0] data, input logic last);
        t_out_word w;
        w.data = data;
        w.last = last;
        run_words_due.push_back(w);
    endfunction

    function automatic void push_decimal(input logic [7:0] v);
        if (v >= 100) push_word(8'(rac_pkg::CH_ZERO + v / 100), 1'b0);
        if (v >= 10) push_word(8'(rac_pkg::CH_ZERO + (v / 10) % 10), 1'b0);
        push_word(8'(rac_pkg::CH_ZERO + v % 10), 1'b0);
    endfunction

    // Work out the run of words that one accepted text byte causes
    function automatic void predict_colour_run(input logic [7:0] c);
        rac_pkg::t_phase a;
        logic [7:0]      r;
        logic [7:0]      g;
        logic [7:0]      b;
        if (!pr_enable) begin
            push_word(c, 1'b1);
        end else if (c == rac_pkg::CH_ESC) begin
            pr_in_escape = 1'b1;
        end else if (pr_in_escape) begin
            // Swallow; a letter or BEL closes the sequence
            if ((c >= rac_pkg::CH_UPPER_A && c <= rac_pkg::CH_UPPER_Z)
                    || (c >= rac_pkg::CH_LOWER_A && c <= rac_pkg::CH_LOWER_Z)
                    || c == rac_pkg::CH_BEL) begin
                pr_in_escape = 1'b0;
            end
        end else begin
            a            = pr_col_phase + pr_line_phase;
            r            = rainbow_level(a);
            g            = rainbow_level(a + rac_pkg::PH_THIRD);
            b            = rainbow_level(a + rac_pkg::PH_TWO_THIRDS);
            pr_col_phase = pr_col_phase + pr_col_step;
            if (!pr_true_color) begin
                r = r >> 6;
                g = g >> 6;
                b = b >> 6;
            end
            // Emit an escape only when the colour moves
            if (r != pr_last_red || g != pr_last_green || b != pr_last_blue) begin
                push_word(rac_pkg::CH_ESC, 1'b0);
                push_word(rac_pkg::CH_LBRACKET, 1'b0);
                if (pr_true_color) begin
                    push_word(pr_invert ? rac_pkg::CH_FOUR : rac_pkg::CH_THREE, 1'b0);
                    push_word(rac_pkg::CH_EIGHT, 1'b0);
                    push_word(rac_pkg::CH_SEMI, 1'b0);
                    push_word(rac_pkg::CH_TWO, 1'b0);
                    push_word(rac_pkg::CH_SEMI, 1'b0);
                    push_decimal(r);
                    push_word(rac_pkg::CH_SEMI, 1'b0);
                    push_decimal(g);
                    push_word(rac_pkg::CH_SEMI, 1'b0);
                    push_decimal(b);
                end else begin
                    if (pr_invert) begin
                        push_word(rac_pkg::CH_SEVEN, 1'b0);
                        push_word(rac_pkg::CH_SEMI, 1'b0);
                    end
                    if (r[1] || b[1] || c[1]) begin
                        push_word(rac_pkg::CH_ONE, 1'b0);
                    end else begin
                        push_word(rac_pkg::CH_TWO, 1'b0);
                        push_word(rac_pkg::CH_ONE, 1'b0);
                    end
                    push_word(rac_pkg::CH_SEMI, 1'b0);
                    push_word(rac_pkg::CH_THREE, 1'b0);
                    push_word(8'(rac_pkg::CH_ZERO + (r != 0) + 2 * (g != 0) + 4 * (b != 0)),
                              1'b0);
                end
                push_word(rac_pkg::CH_M, 1'b0);
                pr_last_red   = r;
                pr_last_green = g;
                pr_last_blue  = b;
            end
            push_word(c, 1'b1);
            if (c == rac_pkg::CH_NL) begin
                pr_line_phase = pr_line_phase + pr_line_step;
                pr_col_phase  = '0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] value);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_colour_run(value);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic write_register(input logic [rac_pkg::CFG_INDEX_BITS-1:0] index,
                                  input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(index, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop the input, let every expected word out, then let swallowed bytes settle
    task automatic wait_for_idle();
        s_axis_tvalid = 1'b0;
        while (run_words_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_letter();
        int unsigned pick;
        pick = $urandom_range(0, 51);
        return (pick < 26) ? 8'(rac_pkg::CH_UPPER_A + pick)
                           : 8'(rac_pkg::CH_LOWER_A + pick - 26);
    endfunction

    function automatic logic [15:0] pick_step();
        logic [15:0] step;
        case ($urandom_range(0, 4))
            0:       step = 16'h0000;
            1:       step = 16'hFFFF;
            2:       step = 16'h4000;
            default: step = 16'($urandom);
        endcase
        return step;
    endfunction

    // Mostly printable text and newlines, with well-formed and broken escapes mixed in
    task automatic send_random_text(input int count);
        int          start;
        int unsigned pick;
        int unsigned n;
        start = sent_count;
        while (sent_count - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_byte(8'($urandom_range(32, 126)));
            end else if (pick < 65) begin
                send_byte(rac_pkg::CH_NL);
            end else if (pick < 80) begin
                send_byte(8'($urandom));
            end else if (pick < 92) begin
                // CSI: ESC [ params letter
                send_byte(rac_pkg::CH_ESC);
                send_byte(rac_pkg::CH_LBRACKET);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) send_byte(rac_pkg::CH_SEMI);
                    else send_byte(8'(rac_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
                send_byte(random_letter());
            end else if (pick < 96) begin
                // OSC-like: ESC ] digits closed by BEL
                send_byte(rac_pkg::CH_ESC);
                send_byte(CH_RBRACKET);
                repeat ($urandom_range(0, 4)) begin
                    send_byte(8'(rac_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
                send_byte(rac_pkg::CH_BEL);
            end else begin
                // Broken: a second ESC restarts, any byte may follow
                send_byte(rac_pkg::CH_ESC);
                if ($urandom_range(0, 1) == 0) send_byte(rac_pkg::CH_ESC);
                send_byte(8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output sink: random bursts of back-pressure and the long hold-off
    // ------------------------------------------------------------------

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                m_axis_tready = 1'b0;
                stall_request--;
            end else if (sink_gap > 0) begin
                m_axis_tready = 1'b0;
                sink_gap--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                sink_gap      = $urandom_range(0, 18);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expected word
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string what, input t_out_word want,
                                            input t_out_word got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
                     $realtime, what, want.data, want.last, got.data, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data = m_axis_tdata;
            got.last = m_axis_tlast;
            if (run_words_due.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = run_words_due.pop_front();
                if (got.data !== want.data) report_mismatch("out_byte mismatch", want, got);
                else if (got.last !== want.last) report_mismatch("tlast mismatch", want, got);
            end
        end
    end

    // Watchdog: stop when no channel moves a word for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("FAIL rainbow_ansi_text_colorizer");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 16-colour form, default steps, bold chosen by the text byte too
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(rac_pkg::CH_NL);
        send_text("b");
    endtask

    // Escapes swallowed: repeated ESC, non-letters near the letter ranges, each closer
    task automatic test_escape_swallowing();
        send_byte(rac_pkg::CH_ESC);
        send_byte(rac_pkg::CH_ESC);
        send_text("@[`{A");
        send_byte(rac_pkg::CH_ESC);
        send_text("Z");
        send_byte(rac_pkg::CH_ESC);
        send_text("a");
        send_byte(rac_pkg::CH_ESC);
        send_text("z");
        send_byte(rac_pkg::CH_ESC);
        send_byte(rac_pkg::CH_BEL);
        send_text("x");
    endtask

    // 24-bit form with quarter-turn steps to hit the exact peaks and zero crossings
    task automatic test_true_colour();
        wait_for_idle();
        write_register(rac_pkg::CFG_TRUE_COLOR, 16'hFFFF);
        write_register(rac_pkg::CFG_COLUMN_STEP, 16'h4000);
        write_register(rac_pkg::CFG_LINE_STEP, 16'hFFFF);
        send_text("ab\nc");
    endtask

    // Background colour, then back to 16-colour with stale 8-bit last colour
    task automatic test_invert_and_modes();
        wait_for_idle();
        write_register(rac_pkg::CFG_INVERT, 16'h0001);
        send_text("d");
        wait_for_idle();
        write_register(rac_pkg::CFG_TRUE_COLOR, 16'h0000);
        write_register(rac_pkg::CFG_COLUMN_STEP, 16'h0000);
        send_text("eff");
    endtask

    // Pass-through with colouring off; writes to unused indexes change nothing
    task automatic test_passthrough_and_spare_registers();
        wait_for_idle();
        write_register(rac_pkg::CFG_ENABLE, 16'hFFFE);
        send_byte(rac_pkg::CH_ESC);
        send_text("q");
        wait_for_idle();
        for (int i = int'(CFG_SPARE_FIRST); i <= int'(CFG_SPARE_LAST); i++) begin
            write_register(rac_pkg::CFG_INDEX_BITS'(i), 16'($urandom));
        end
        write_register(rac_pkg::CFG_ENABLE, 16'hFFFF);
        write_register(rac_pkg::CFG_INVERT, 16'h0000);
        send_text("q");
    endtask

    // Random text over several random settings, every true-colour and invert combination
    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            wait_for_idle();
            write_register(rac_pkg::CFG_COLUMN_STEP, pick_step());
            write_register(rac_pkg::CFG_LINE_STEP, pick_step());
            write_register(rac_pkg::CFG_TRUE_COLOR, {15'($urandom), p[0]});
            write_register(rac_pkg::CFG_INVERT, {15'($urandom), p[1]});
            write_register(rac_pkg::CFG_ENABLE,
                           {15'($urandom), ($urandom_range(0, 5) != 0)});
            send_random_text(55);
        end
    endtask

    // Hold the sink off long enough for the pipeline to fill and stall the input
    task automatic test_output_backpressure();
        wait_for_idle();
        write_register(rac_pkg::CFG_ENABLE, 16'h0001);
        write_register(rac_pkg::CFG_TRUE_COLOR, 16'h0001);
        write_register(rac_pkg::CFG_COLUMN_STEP, 16'(rac_pkg::RST_COLUMN_STEP));
        stall_request = LONG_STALL;
        send_random_text(40);
    endtask

    // Back-to-back stream with no idling on either side
    task automatic test_steady_stream();
        wait_for_idle();
        idle_on  = 1'b0;
        sink_gap = 0;
        write_register(rac_pkg::CFG_TRUE_COLOR, 16'h0000);
        write_register(rac_pkg::CFG_LINE_STEP, 16'(rac_pkg::RST_LINE_STEP));
        send_random_text(40);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = rac_pkg::CFG_COLUMN_STEP;
        i_cfg_data    = '0;
        reset_predictor();
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_escape_swallowing();
        test_true_colour();
        test_invert_and_modes();
        test_passthrough_and_spare_registers();
        test_random_settings();
        test_output_backpressure();
        test_steady_stream();
        wait_for_idle();

        if (fail_count == 0 && run_words_due.size() == 0) begin
            $display("PASS rainbow_ansi_text_colorizer");
        end else begin
            $display("FAIL rainbow_ansi_text_colorizer");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rac_pkg.sv
rtl/rac_colour.sv
rtl/rac_format.sv
rtl/rainbow_ansi_text_colorizer.sv
dv/rainbow_ansi_text_colorizer_test.sv
